### src/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the control structs that pass between the front end,
// the queue and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  localparam int NUM_W_DEF   = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic push;
    logic skip;
  } tdp_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tdp_qstat_t;

endpackage

`default_nettype wire

### src/tdp_front.sv
// ----------------------------------------------------------------------------
// Trial division front end
// Accepts an input beat when the queue has room and marks numbers below two,
// which are settled as not prime without any division.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_front
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  wire logic                    start,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  input  wire tdp_qstat_t              qstat,
  output tdp_push_t                    push_ctl,
  output logic      [NUMBER_WIDTH-1:0] push_number
);

  always_comb begin
    push_ctl.push = start && !qstat.full;
    push_ctl.skip = (in_number[NUMBER_WIDTH-1:1] == '0);
    push_number   = in_number;
  end

endmodule

`default_nettype wire

### src/tdp_queue.sv
// ----------------------------------------------------------------------------
// Trial division work queue
// A short first-in first-out queue of classified numbers between the front
// end and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_queue
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tdp_push_t               push_ctl,
  input  wire logic [NUMBER_WIDTH-1:0] push_number,
  input  wire logic                    pop,
  output tdp_qstat_t                   qstat,
  output logic      [NUMBER_WIDTH-1:0] head_number,
  output logic                         head_skip
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [NUMBER_WIDTH-1:0] num_mem [QUEUE_DEPTH];
  logic                    skip_mem [QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    qstat.full  = (count_r == CW'(QUEUE_DEPTH));
    qstat.empty = (count_r == '0);
    do_push     = push_ctl.push && !qstat.full;
    do_pop      = pop && !qstat.empty;
    head_number = num_mem[rd_ptr_r];
    head_skip   = skip_mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      num_mem[wr_ptr_r]  <= push_number;
      skip_mem[wr_ptr_r] <= push_ctl.skip;
    end
  end

endmodule

`default_nettype wire

### src/tdp_back.sv
// ----------------------------------------------------------------------------
// Trial division back end
// Steps the candidate divisor upward from two while its square stays within
// the number, computing each remainder with a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_back
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tdp_qstat_t              qstat,
  input  wire logic [NUMBER_WIDTH-1:0] head_number,
  input  wire logic                    head_skip,
  output logic                         pop,
  output logic                         out_valid,
  output logic                         out_is_prime
);

  localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int SW = NUMBER_WIDTH + 2;
  localparam int BW = $clog2(NUMBER_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BOUND = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] num_r, num_nxt;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SW-1:0]           sq_r, sq_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [BW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_is_prime_r, out_is_prime_nxt;
  logic [DW:0]             trial;
  logic [DW:0]             trial_sub;

  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    pop              = 1'b0;
    trial            = {rem_r, num_r[cnt_r]};
    trial_sub        = trial - {1'b0, d_r};

    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (head_skip) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
          end else begin
            num_nxt   = head_number;
            d_nxt     = DW'(2);
            sq_nxt    = SW'(4);
            state_nxt = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        if (sq_r > SW'(num_r)) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = BW'(NUMBER_WIDTH - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = trial_sub[DW-1:0];
        end else begin
          rem_nxt = trial[DW-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (rem_nxt == '0) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
            state_nxt        = ST_IDLE;
          end else begin
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + SW'({d_r, 1'b1});
            state_nxt = ST_BOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r          <= num_nxt;
    d_r            <= d_nxt;
    sq_r           <= sq_nxt;
    rem_r          <= rem_nxt;
    cnt_r          <= cnt_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

`ifndef NO_ASSERTIONS
  a_div_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (d_r >= DW'(2)))
    else $error("divider running with a divisor below two");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("partial remainder not below the divisor");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result beat while a number is still in work");

  a_prime_from_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_prime_r) |-> ($past(state_r) == ST_BOUND))
    else $error("prime reported without the square bound being passed");
`endif

endmodule

`default_nettype wire

### src/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Reports for each number whether it is prime by trial division.
//
//   Channel  Ports                 Transfer
//   input    start, in_number      beat taken when start is high, busy low
//   result   out_valid, out_is_prime  one-cycle strobe, always taken
//
// Each candidate divisor passes one bound check and then the bit-serial
// remainder unit. A composite n is reported once its smallest factor
// divides it, a prime once the square of the candidate divisor exceeds n,
// and a number below two without any division.
// The queue holds two numbers; busy is high while it is full. Reset is
// synchronous and active low; it empties the queue and idles the divider.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test_top
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  output logic                         out_valid,
  output logic                         out_is_prime
);

  tdp_push_t               push_ctl;
  tdp_qstat_t              qstat;
  logic [NUMBER_WIDTH-1:0] push_number;
  logic [NUMBER_WIDTH-1:0] head_number;
  logic                    head_skip;
  logic                    pop;

  tdp_front #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_front (
    .start      (start),
    .in_number  (in_number),
    .qstat      (qstat),
    .push_ctl   (push_ctl),
    .push_number(push_number)
  );

  tdp_queue #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ctl   (push_ctl),
    .push_number(push_number),
    .pop        (pop),
    .qstat      (qstat),
    .head_number(head_number),
    .head_skip  (head_skip)
  );

  tdp_back #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .qstat       (qstat),
    .head_number (head_number),
    .head_skip   (head_skip),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  assign busy = qstat.full;

endmodule

`default_nettype wire
